// ===== rtl/impcf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the pitch complementary filter
package impcf_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_GYRO_GAIN      = 2'd0;
   localparam logic [1:0] REG_KEEP_WEIGHT    = 2'd1;
   localparam logic [1:0] REG_MAGNITUDE_LOW  = 2'd2;
   localparam logic [1:0] REG_MAGNITUDE_HIGH = 2'd3;

   localparam logic [15:0] GYRO_GAIN_RESET      = 16'd640;
   localparam logic [16:0] KEEP_WEIGHT_RESET    = 17'd58982;
   localparam logic [16:0] MAGNITUDE_LOW_RESET  = 17'd8192;
   localparam logic [16:0] MAGNITUDE_HIGH_RESET = 17'd32768;

   localparam int CFG_W      = 17;
   localparam int XY_W       = 36;  // cordic vector, raw << 16 plus growth
   localparam int ANG_W      = 34;  // cordic angle, degrees q24
   localparam int TABLE_LEN  = 24;
   localparam int TABLE_FRAC = 24;
   localparam int PROD_W     = 50;  // 32 x 18 signed product
   localparam int SAT_W      = 35;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic signed [ANG_W-1:0] HALF_TURN_Q24 = 34'sd3019898880;

   typedef struct packed {
      logic [15:0] gyro_gain;
      logic [16:0] keep_weight;
      logic [16:0] magnitude_low;
      logic [16:0] magnitude_high;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic gyro_mul;
      logic gyro_add;
      logic cordic_init;
      logic cordic_step;
      logic angle_round;
      logic mul_keep;
      logic mul_accel;
      logic blend;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_window;
      logic last_step;
   } status_type;

   // arctan(2^-i) in degrees, q24
   function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489089;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509719;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234684;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29336;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

   // clamp to the signed 32-bit pitch range
   function automatic logic signed [31:0] sat_pitch(input logic signed [SAT_W-1:0] v);
      logic signed [31:0] r;
      if (v > $signed({{(SAT_W-31){1'b0}}, {31{1'b1}}})) begin
         r = 32'sh7FFFFFFF;
      end else if (v < $signed({{(SAT_W-31){1'b1}}, {31{1'b0}}})) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/imu_pitch_complementary_filter_top.sv =====
`timescale 1ns / 1ps
// top level of the imu pitch complementary filter
//
// Each req transfer carries one raw imu sample and yields exactly one rsp
// transfer holding the updated pitch (degrees, signed q16 by default) and a
// flag telling whether the accelerometer correction was blended in. The block
// works on one sample at a time: a sample that falls outside the magnitude
// window only goes through the gyro step, while one inside the window also
// runs the cordic iterations, one rotation per cycle on a single shift-add
// unit, followed by two passes through the one shared 32 x 18 multiplier. A
// finished result sits in the rsp output register, so the next sample is taken
// while the previous result still waits for rsp_tready. The user must write the
// configuration through the csr port only while the block is idle; the block
// itself does not enforce this. The pitch state resets to zero.
module imu_pitch_complementary_filter_top
   import impcf_pkg::*;
#(
   parameter int CORDIC_STEPS        = 16,  // cordic rotations, 8 to 24
   parameter int ANGLE_FRACTION_BITS = 16   // fraction bits of the pitch, 8 to 20
) (
   input  logic             clock,
   input  logic             reset,
   // sample stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,   // gyro_rate_y, accel_x, accel_y, accel_z
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // pitch_angle
   output logic             rsp_tuser,   // correction_applied
   // register writes
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // gain, blend weight and magnitude window registers
   impcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: gyro step, optional cordic and blend, then result hand-off
   impcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, pitch state and the output register
   impcf_dp #(
      .CORDIC_STEPS        (CORDIC_STEPS),
      .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .status    (status),
      .pitch_out (rsp_tdata),
      .corr_out  (rsp_tuser)
   );

endmodule

// ===== rtl/impcf_csr.sv =====
`timescale 1ns / 1ps
// configuration registers of the pitch filter
module impcf_csr
   import impcf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CFG_W-1:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_GYRO_GAIN:      cfg_in.gyro_gain      = csr_wdata[15:0];
            REG_KEEP_WEIGHT:    cfg_in.keep_weight    = csr_wdata;
            REG_MAGNITUDE_LOW:  cfg_in.magnitude_low  = csr_wdata;
            REG_MAGNITUDE_HIGH: cfg_in.magnitude_high = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gyro_gain      <= GYRO_GAIN_RESET;
         cfg_ff.keep_weight    <= KEEP_WEIGHT_RESET;
         cfg_ff.magnitude_low  <= MAGNITUDE_LOW_RESET;
         cfg_ff.magnitude_high <= MAGNITUDE_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/impcf_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine of the pitch filter
module impcf_ctrl
   import impcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_GYRO_MUL    = 4'd1;
   localparam logic [3:0] S_GYRO_ADD    = 4'd2;
   localparam logic [3:0] S_CORDIC_INIT = 4'd3;
   localparam logic [3:0] S_CORDIC_STEP = 4'd4;
   localparam logic [3:0] S_ANGLE_ROUND = 4'd5;
   localparam logic [3:0] S_MUL_KEEP    = 4'd6;
   localparam logic [3:0] S_MUL_ACCEL   = 4'd7;
   localparam logic [3:0] S_BLEND       = 4'd8;
   localparam logic [3:0] S_DONE        = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       slot_free;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_GYRO_MUL;
            end
         end
         S_GYRO_MUL: begin
            cmd.gyro_mul = 1'b1;
            state_in     = S_GYRO_ADD;
         end
         S_GYRO_ADD: begin
            cmd.gyro_add = 1'b1;
            state_in     = status.in_window ? S_CORDIC_INIT : S_DONE;
         end
         S_CORDIC_INIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = S_CORDIC_STEP;
         end
         S_CORDIC_STEP: begin
            cmd.cordic_step = 1'b1;
            if (status.last_step) begin
               state_in = S_ANGLE_ROUND;
            end
         end
         S_ANGLE_ROUND: begin
            cmd.angle_round = 1'b1;
            state_in        = S_MUL_KEEP;
         end
         S_MUL_KEEP: begin
            cmd.mul_keep = 1'b1;
            state_in     = S_MUL_ACCEL;
         end
         S_MUL_ACCEL: begin
            cmd.mul_accel = 1'b1;
            state_in      = S_BLEND;
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_GYRO_MUL)
      else $error("accepted transfer did not start the gyro step");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while still held");

   a_cordic_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CORDIC_STEP && status.last_step |=> state_ff == S_ANGLE_ROUND)
      else $error("cordic did not stop after its last step");

endmodule

// ===== rtl/impcf_dp.sv =====
`timescale 1ns / 1ps
// datapath: gyro integration, magnitude window, cordic atan2 and blend
module impcf_dp
   import impcf_pkg::*;
#(
   parameter int CORDIC_STEPS        = 16,
   parameter int ANGLE_FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   input  logic [63:0] req_tdata,
   output status_type  status,
   output logic [31:0] pitch_out,
   output logic        corr_out
);

   localparam int STEPS_EFF = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int ITER_W    = $clog2(STEPS_EFF);
   localparam int RND_SHIFT = TABLE_FRAC - ANGLE_FRACTION_BITS;

   logic signed [15:0] gyro_ff, ax_ff, az_ff;
   logic [16:0]        mag_ff;
   logic signed [31:0] pitch_ff, pitch_in;
   logic               corr_ff;
   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic               zero_ff;
   logic [ITER_W-1:0]  iter_ff;
   logic signed [31:0] angle_ff;
   logic signed [PROD_W-1:0] prod_ff, sum_ff;
   logic [31:0]        out_pitch_ff;
   logic               out_corr_ff;

   // input unpacking and l1 magnitude
   logic signed [15:0] in_g, in_ax, in_ay, in_az;
   logic [16:0]        abs_ax, abs_ay, abs_az, mag_new;

   assign in_g  = req_tdata[15:0];
   assign in_ax = req_tdata[31:16];
   assign in_ay = req_tdata[47:32];
   assign in_az = req_tdata[63:48];
   assign abs_ax = in_ax[15] ? 17'd0 - {in_ax[15], in_ax} : {1'b0, in_ax};
   assign abs_ay = in_ay[15] ? 17'd0 - {in_ay[15], in_ay} : {1'b0, in_ay};
   assign abs_az = in_az[15] ? 17'd0 - {in_az[15], in_az} : {1'b0, in_az};
   assign mag_new = abs_ax + abs_ay + abs_az;

   assign status.in_window = (mag_ff > cfg.magnitude_low) && (mag_ff < cfg.magnitude_high);
   assign status.last_step = (iter_ff == ITER_W'(STEPS_EFF - 1));

   // blend weights, keep weight clamped to one
   logic [16:0] keep_w, accel_w;
   assign keep_w  = (cfg.keep_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.keep_weight;
   assign accel_w = WEIGHT_ONE - keep_w;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [PROD_W-1:0] mul_res;

   always_comb begin
      if (cmd.mul_keep) begin
         mul_a = pitch_ff;
         mul_b = $signed({1'b0, keep_w});
      end else if (cmd.mul_accel) begin
         mul_a = angle_ff;
         mul_b = $signed({1'b0, accel_w});
      end else begin
         mul_a = $signed({{16{gyro_ff[15]}}, gyro_ff});
         mul_b = $signed({2'b00, cfg.gyro_gain});
      end
   end
   assign mul_res = mul_a * mul_b;

   // gyro step
   logic signed [PROD_W-1:0] delta;
   logic signed [SAT_W-1:0]  gyro_sum;
   assign delta    = (prod_ff + PROD_W'(128)) >>> 8;
   assign gyro_sum = $signed({{(SAT_W-32){pitch_ff[31]}}, pitch_ff}) + delta[SAT_W-1:0];

   // blend
   logic signed [PROD_W:0]  blend_tot, blend_shr;
   assign blend_tot = $signed({sum_ff[PROD_W-1], sum_ff}) + $signed({prod_ff[PROD_W-1], prod_ff})
                    + $signed((PROD_W+1)'(32768));
   assign blend_shr = blend_tot >>> 16;

   always_comb begin
      pitch_in = pitch_ff;
      if (cmd.gyro_add) begin
         pitch_in = sat_pitch(gyro_sum);
      end else if (cmd.blend) begin
         pitch_in = sat_pitch(blend_shr[SAT_W-1:0]);
      end
   end

   // cordic start: (x, y) = (-ax, az), mirrored into the right half plane
   logic signed [16:0] nax, az17, x0, y0;
   logic               left_half;
   assign nax       = -$signed({ax_ff[15], ax_ff});
   assign az17      = $signed({az_ff[15], az_ff});
   assign left_half = nax < 0;
   assign x0        = left_half ? -nax : nax;
   assign y0        = left_half ? -az17 : az17;

   // one cordic rotation
   logic signed [XY_W-1:0]  xs, ys;
   logic signed [ANG_W-1:0] atan_i;
   assign xs     = x_ff >>> iter_ff;
   assign ys     = y_ff >>> iter_ff;
   assign atan_i = atan_q24(5'(iter_ff));

   logic signed [ANG_W-1:0] ang_rnd;
   assign ang_rnd = (ang_ff + $signed(ANG_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
      end else begin
         pitch_ff <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gyro_ff <= in_g;
         ax_ff   <= in_ax;
         az_ff   <= in_az;
         mag_ff  <= mag_new;
      end
      if (cmd.gyro_mul || cmd.mul_keep || cmd.mul_accel) begin
         prod_ff <= mul_res;
      end
      if (cmd.mul_accel) begin
         sum_ff <= prod_ff;
      end
      if (cmd.gyro_add) begin
         corr_ff <= status.in_window;
      end
      if (cmd.cordic_init) begin
         x_ff    <= $signed({{(XY_W-33){x0[16]}}, x0, 16'd0});
         y_ff    <= $signed({{(XY_W-33){y0[16]}}, y0, 16'd0});
         ang_ff  <= left_half ? ((az17 >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24) : '0;
         zero_ff <= (ax_ff == 16'sd0) && (az_ff == 16'sd0);
         iter_ff <= '0;
      end else if (cmd.cordic_step) begin
         if (y_ff > 0) begin
            x_ff   <= x_ff + ys;
            y_ff   <= y_ff - xs;
            ang_ff <= ang_ff + atan_i;
         end else begin
            x_ff   <= x_ff - ys;
            y_ff   <= y_ff + xs;
            ang_ff <= ang_ff - atan_i;
         end
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.angle_round) begin
         angle_ff <= zero_ff ? 32'sd0 : ang_rnd[31:0];
      end
      if (cmd.load_out) begin
         out_pitch_ff <= pitch_ff;
         out_corr_ff  <= corr_ff;
      end
   end

   assign pitch_out = out_pitch_ff;
   assign corr_out  = out_corr_ff;

   a_blend_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.blend |-> corr_ff)
      else $error("blend without an in-window magnitude");

   a_cordic_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_init |=> iter_ff == '0)
      else $error("cordic step counter not cleared at start");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the imu pitch complementary filter: directed table, then random phases
module testbench
   import impcf_pkg::*;
();

   localparam int ROTATIONS   = 16;              // cordic rotations of the instance
   localparam int FRAC_BITS   = 16;              // fraction bits of the pitch
   localparam int ANGLE_SHIFT = 24 - FRAC_BITS;  // q24 degrees down to the pitch format
   localparam int IDLE_LIMIT  = 2000;            // cycles with no transfer before giving up
   localparam int HOLD_AT     = 500;             // result count at which the long hold starts
   localparam int HOLD_CYCLES = 300;
   localparam longint STRAIGHT_ANGLE_Q24 = 64'sd3019898880;  // 180 degrees, q24

   typedef enum logic [1:0] {
      MIXED,   // plausible, noisy and special accel vectors, gyro anywhere
      CLIMB,   // gyro pinned near full positive rate
      DIVE     // gyro pinned near full negative rate
   } sample_style_type;

   typedef struct packed {
      logic [31:0] pitch;
      logic        corr;
   } pitch_expect_type;

   typedef struct packed {
      logic [15:0] gyro;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] az;
      logic        typed;  // result written in below rather than predicted
      logic [31:0] pitch;
      logic        corr;
   } directed_row_type;

   // clock, reset and block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // gyro_rate_y, accel_x, accel_y, accel_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pitch_angle
   logic        rsp_tuser;        // correction_applied
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = REG_GYRO_GAIN;
   logic [CFG_W-1:0] csr_wdata = '0;

   // shadow of the block's registers and pitch state
   logic [15:0]        gain_q8   = GYRO_GAIN_RESET;
   logic [16:0]        keep_q16  = KEEP_WEIGHT_RESET;
   logic [16:0]        mag_low   = MAGNITUDE_LOW_RESET;
   logic [16:0]        mag_high  = MAGNITUDE_HIGH_RESET;
   logic signed [31:0] pitch_track = '0;

   pitch_expect_type pending_pitch [$];

   int  failures        = 0;
   int  samples_sent    = 0;
   int  results_checked = 0;
   int  corrections     = 0;
   int  saturated_seen  = 0;
   int  idle_cycles     = 0;
   bit  no_idle         = 1'b0;  // both sides run without gaps
   bit  hold_done       = 1'b0;

   // arctan(2^-i) in degrees, q24
   longint arctan_deg_q24 [24] = '{
      754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
      15018523, 7509719, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29336, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   // reset values are easy to read off for the first rows, the rest is predicted
   directed_row_type directed_rows [21] = '{
      // all zero after reset
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 32'sd0, 1'b0},
      // smallest rates, rounding of halves upward
      '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 32'sd3, 1'b0},
      '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 32'sd1, 1'b0},
      // most negative rate
      '{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1, -32'sd81919, 1'b0},
      // zero vector in the window gives angle 0
      '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // straight up, 90 degrees
      '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 32'sd0, 1'b0},
      // left half plane on the axis gives +180
      '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // left half plane just below the axis gives -180 side
      '{16'sd0, 16'sd16384, 16'sd0, -16'sd1, 1'b0, 32'sd0, 1'b0},
      '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // upper window bound is exclusive
      '{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{16'sd0, -16'sd32767, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // lower window bound is exclusive
      '{16'sd0, -16'sd8192, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{16'sd0, -16'sd8193, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // field extremes, far outside the window
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 32'sd0, 1'b0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 32'sd0, 1'b0},
      // diagonals with full rates
      '{16'sd32767, -16'sd11585, 16'sd0, 16'sd11585, 1'b0, 32'sd0, 1'b0},
      '{16'sh8000, 16'sd11585, 16'sd2000, -16'sd11585, 1'b0, 32'sd0, 1'b0},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0, 32'sd0, 1'b0},
      '{16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 1'b0, 32'sd0, 1'b0},
      // magnitude made up mostly of accel y, on and just past the lower bound
      '{-16'sd1, 16'sd1, 16'sd8190, 16'sd1, 1'b0, 32'sd0, 1'b0},
      '{16'sd1, -16'sd1, -16'sd8191, -16'sd1, 1'b0, 32'sd0, 1'b0}
   };

   imu_pitch_complementary_filter_top #(
      .CORDIC_STEPS       (ROTATIONS),
      .ANGLE_FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [31:0] clamp_pitch(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // atan2(y, x) in degrees with FRAC_BITS fraction bits, shift-add rotations
   function automatic longint accel_angle_deg(input longint y_raw, input longint x_raw);
      longint x;
      longint y;
      longint ang;
      longint xs;
      longint ys;
      if (x_raw == 0 && y_raw == 0) return 0;
      x   = x_raw * 65536;
      y   = y_raw * 65536;
      ang = 0;
      // fold the left half plane over, starting from a half turn
      if (x < 0) begin
         ang = (y >= 0) ? STRAIGHT_ANGLE_Q24 : -STRAIGHT_ANGLE_Q24;
         x   = -x;
         y   = -y;
      end
      for (int i = 0; i < ROTATIONS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x   = x + ys;
            y   = y - xs;
            ang = ang + arctan_deg_q24[i];
         end else begin
            x   = x - ys;
            y   = y + xs;
            ang = ang - arctan_deg_q24[i];
         end
      end
      if (ANGLE_SHIFT > 0) ang = (ang + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      return ang;
   endfunction

   // advance the shadow pitch by one sample and give the result it must produce
   task automatic predict_pitch(input logic [63:0] smp, output pitch_expect_type res);
      longint gyro;
      longint ax;
      longint ay;
      longint az;
      longint mag;
      longint weight;
      longint blend;
      gyro = longint'($signed(smp[15:0]));
      ax   = longint'($signed(smp[31:16]));
      ay   = longint'($signed(smp[47:32]));
      az   = longint'($signed(smp[63:48]));
      // gyro integration, halves rounded upward
      pitch_track = clamp_pitch(longint'(pitch_track)
                                + ((gyro * longint'(gain_q8) + 128) >>> 8));
      mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
      res.corr = 1'b0;
      if (mag > longint'(mag_low) && mag < longint'(mag_high)) begin
         weight = (keep_q16 > WEIGHT_ONE) ? 64'sd65536 : longint'(keep_q16);
         blend  = longint'(pitch_track) * weight
                  + accel_angle_deg(az, -ax) * (64'sd65536 - weight);
         pitch_track = clamp_pitch((blend + 32768) >>> 16);
         res.corr = 1'b1;
      end
      res.pitch = pitch_track;
   endtask

   function automatic int signed_span(input int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 3))
         0:       return 16'sh8000;
         1:       return 16'sd32767;
         2:       return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   function automatic logic [63:0] draw_sample(input sample_style_type style);
      logic [15:0] gyro;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] az;
      int          pick;
      case (style)
         CLIMB:   gyro = 16'($urandom_range(31000, 32767));
         DIVE:    gyro = 16'(-int'($urandom_range(31000, 32768)));
         default: gyro = ($urandom_range(0, 99) < 85) ? 16'($urandom) : pick_extreme();
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         // roughly one g in the x-z plane with some sideways noise
         ax = 16'(signed_span(20000));
         ay = 16'(signed_span(4000));
         az = 16'(signed_span(20000));
      end else if (pick < 80) begin
         ax = 16'($urandom);
         ay = 16'($urandom);
         az = 16'($urandom);
      end else if (pick < 95) begin
         ay = 16'(signed_span(100));
         case ($urandom_range(0, 4))
            0: begin
               // zero vector, magnitude carried by y alone
               ax = '0;
               az = '0;
               ay = 16'(signed_span(20000));
            end
            1: begin
               // negative x axis exactly
               ax = 16'($urandom_range(8000, 20000));
               az = '0;
            end
            2: begin
               // just below the negative x axis
               ax = 16'($urandom_range(8000, 20000));
               az = 16'(-int'($urandom_range(1, 50)));
            end
            3: begin
               ax = $urandom_range(0, 1) ? 16'sh8000 : 16'sd32767;
               az = 16'(signed_span(100));
            end
            default: begin
               ax = 16'(signed_span(100));
               az = $urandom_range(0, 1) ? 16'sh8000 : 16'sd32767;
            end
         endcase
      end else begin
         ax = pick_extreme();
         ay = pick_extreme();
         az = pick_extreme();
      end
      return {az, ay, ax, gyro};
   endfunction

   // offer one sample after a random gap (none while no_idle is set) and queue its result once the transfer happens
   task automatic send_sample(input logic [63:0] smp, input bit typed,
                              input pitch_expect_type typed_res);
      int               gap;
      pitch_expect_type res;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= smp;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pitch(smp, res);
      pending_pitch.push_back(typed ? typed_res : res);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CFG_W-1:0];
      case (idx)
         REG_GYRO_GAIN:      gain_q8  = value[15:0];
         REG_KEEP_WEIGHT:    keep_q16 = value[16:0];
         REG_MAGNITUDE_LOW:  mag_low  = value[16:0];
         REG_MAGNITUDE_HIGH: mag_high = value[16:0];
         default:            ;
      endcase
   endtask

   // drain, reprogram all four registers, then stream a batch of samples
   task automatic run_phase(input int unsigned gain, input int unsigned keep,
                            input int unsigned low, input int unsigned high,
                            input int count, input sample_style_type style,
                            input bit steady);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_pitch.size() == 0);
      write_reg(REG_GYRO_GAIN, gain);
      write_reg(REG_KEEP_WEIGHT, keep);
      write_reg(REG_MAGNITUDE_LOW, low);
      write_reg(REG_MAGNITUDE_HIGH, high);
      @(negedge clock);
      csr_we  <= 1'b0;
      no_idle  = steady;
      repeat (count) send_sample(draw_sample(style), 1'b0, '0);
   endtask

   // result side: random back-pressure, plus one long hold that fills the block up
   initial begin : rsp_pacing
      int hold_off;
      @(negedge clock);
      forever begin
         if (!hold_done && results_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_off  = HOLD_CYCLES;
         end else begin
            hold_off = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : rsp_check
      pitch_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pitch.size() == 0) begin
            $error("unexpected result transfer: pitch_angle %0d, correction_applied %0b",
                   $signed(rsp_tdata), rsp_tuser);
            failures++;
         end else begin
            want = pending_pitch.pop_front();
            if (rsp_tdata !== want.pitch) begin
               $error("pitch_angle mismatch: expected %0d, got %0d",
                      $signed(want.pitch), $signed(rsp_tdata));
               failures++;
            end
            if (rsp_tuser !== want.corr) begin
               $error("correction_applied mismatch: expected %0b, got %0b",
                      want.corr, rsp_tuser);
               failures++;
            end
         end
         results_checked++;
         if (rsp_tuser === 1'b1) corrections++;
         if (rsp_tdata === 32'h7FFFFFFF || rsp_tdata === 32'h80000000) saturated_seen++;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_pitch.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed samples at the reset register values
      foreach (directed_rows[r]) begin
         send_sample({directed_rows[r].az, directed_rows[r].ay,
                      directed_rows[r].ax, directed_rows[r].gyro},
                     directed_rows[r].typed,
                     '{pitch: directed_rows[r].pitch, corr: directed_rows[r].corr});
      end

      // reset values written back explicitly
      run_phase(GYRO_GAIN_RESET, KEEP_WEIGHT_RESET, MAGNITUDE_LOW_RESET,
                MAGNITUDE_HIGH_RESET, 200, MIXED, 1'b0);
      // full gain, inverted window, keep weight above one: drive into positive saturation
      run_phase(65535, 131071, 131071, 0, 300, CLIMB, 1'b1);
      // no gain, accel only, widest window: pitch snaps to the accel angle
      run_phase(0, 0, 0, 131071, 100, MIXED, 1'b0);
      // full gain, empty window: drive into negative saturation
      run_phase(65535, 65536, 98304, 98304, 300, DIVE, 1'b0);
      // random settings, gain written with the unused top bit too
      repeat (3) begin
         run_phase($urandom_range(0, 131071), $urandom_range(40000, 75000),
                   $urandom_range(0, 20000), $urandom_range(12000, 98304),
                   85, MIXED, 1'b0);
      end
      // keep weight exactly one: the blend leaves the pitch alone
      run_phase(1, 65536, 0, 98304, 100, MIXED, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_pitch.size() == 0);
      repeat (40) @(posedge clock);

      if (pending_pitch.size() != 0) begin
         $error("%0d predicted results never arrived", pending_pitch.size());
         failures++;
      end
      $display("run covered %0d samples over eight register settings, %0d results checked",
               samples_sent, results_checked);
      $display("%0d results carried the accel correction, %0d sat at a pitch limit",
               corrections, saturated_seen);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/impcf_pkg.sv
rtl/impcf_csr.sv
rtl/impcf_ctrl.sv
rtl/impcf_dp.sv
rtl/imu_pitch_complementary_filter_top.sv
dv/testbench.sv
